/* rtl/cfr_pkg.sv */
// Shared types and constants for the command frame responder.
// Used by every module of the block; depends on nothing else.
package cfr_pkg;

   localparam int CFG_PAYLOAD_BYTES = 12;
   localparam int LIMIT_COUNT       = 6;
   localparam int SWITCH_COUNT      = 5;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] HEADER_RESET   = 8'hAA;
   localparam logic [7:0] CMD_GET_CFG    = 8'h01;
   localparam logic [7:0] CMD_SET_CFG    = 8'h02;
   localparam logic [7:0] CMD_SAVE       = 8'h03;
   localparam logic [7:0] CMD_SET_SWITCH = 8'h04;
   localparam logic [7:0] RESP_BIT       = 8'h80;
   localparam logic [7:0] RESP_REPORT    = 8'h85;
   localparam logic [7:0] STATUS_OK      = 8'h00;
   localparam logic [7:0] STATUS_BAD_LEN = 8'h01;
   localparam logic [7:0] STATUS_UNKNOWN = 8'hFF;
   localparam logic [7:0] REPORT_LEN     = 8'd11;
   localparam logic [7:0] STATUS_LEN     = 8'd1;

   localparam logic [4:0] SWITCH_MASK = 5'((1 << SWITCH_COUNT) - 1);

   typedef logic [CFG_PAYLOAD_BYTES-1:0][7:0] payload_type;
   typedef logic [LIMIT_COUNT-1:0][15:0]      limits_type;

   // One response frame waiting to be sent.
   typedef struct packed {
      logic [7:0]  header;
      logic [7:0]  cmd;
      logic [7:0]  len;
      payload_type data;
      logic        drive_update;
      logic        save_pulse;
      logic [4:0]  drive_bits;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* rtl/cfr_front.sv */
// Front end: frame parser, configuration state and response job builder.
// Depends on cfr_pkg.
module cfr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,
   input  logic             accept,
   input  logic             opcode,
   input  logic [7:0]       rx_byte,
   input  logic [15:0]      vin_centivolts,
   input  logic [15:0]      current_one_ma,
   input  logic [15:0]      current_two_ma,
   input  logic [15:0]      current_three_ma,
   input  logic [15:0]      current_four_ma,
   input  logic [4:0]       switch_status,
   output logic             push,
   output cfr_pkg::job_type job
);
   import cfr_pkg::*;

   typedef enum logic [1:0] {PH_HUNT, PH_CMD, PH_LEN, PH_DATA} phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_ff, cmd_ff, cmd_in, len_ff, len_in, count_ff, count_in;
   payload_type store_ff, store_in;
   limits_type  limits_ff, limits_in;
   logic [4:0]  switch_ff, switch_in;
   logic        finish;
   logic        ok;
   logic [7:0]  status;

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      store_in  = store_ff;
      limits_in = limits_ff;
      switch_in = switch_ff;
      finish    = 1'b0;
      if (accept && !opcode) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == header_ff) phase_in = PH_CMD;
            end
            PH_CMD: begin
               cmd_in   = rx_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in   = rx_byte;
               count_in = 8'd0;
               if (rx_byte == 8'd0) begin
                  finish   = 1'b1;
                  phase_in = PH_HUNT;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            default: begin
               // Bytes past the store are counted but dropped.
               if (count_ff < 8'(CFG_PAYLOAD_BYTES)) store_in[count_ff[3:0]] = rx_byte;
               count_in = count_ff + 8'd1;
               if (count_in == len_ff) begin
                  finish   = 1'b1;
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end

      // Response for a finished frame; state changes only when finish is set.
      ok     = 1'b0;
      status = STATUS_OK;
      job              = '0;
      job.header       = header_ff;
      job.cmd          = cmd_ff | RESP_BIT;
      job.len          = STATUS_LEN;
      case (cmd_ff)
         CMD_GET_CFG: begin
            if (len_in == 8'd0) begin
               job.len = 8'(2 * LIMIT_COUNT);
               for (int i = 0; i < LIMIT_COUNT; i++) begin
                  job.data[2*i]   = limits_ff[i][15:8];
                  job.data[2*i+1] = limits_ff[i][7:0];
               end
            end else begin
               status = STATUS_BAD_LEN;
            end
         end
         CMD_SET_CFG: begin
            if (len_in == 8'(CFG_PAYLOAD_BYTES)) begin
               ok = 1'b1;
               if (finish) begin
                  for (int i = 0; i < LIMIT_COUNT; i++) begin
                     limits_in[i] = {store_in[2*i], store_in[2*i+1]};
                  end
               end
            end else begin
               status = STATUS_BAD_LEN;
            end
         end
         CMD_SAVE: begin
            if (len_in == 8'd0) begin
               ok             = 1'b1;
               job.save_pulse = 1'b1;
            end else begin
               status = STATUS_BAD_LEN;
            end
         end
         CMD_SET_SWITCH: begin
            if (len_in == 8'd1) begin
               ok               = 1'b1;
               job.drive_update = 1'b1;
               if (finish) switch_in = store_in[0][4:0] & SWITCH_MASK;
            end else begin
               status = STATUS_BAD_LEN;
            end
         end
         default: begin
            status = STATUS_UNKNOWN;
         end
      endcase
      if (job.cmd != (CMD_GET_CFG | RESP_BIT) || ok || status != STATUS_OK) begin
         job.data[0] = status;
      end

      if (opcode) begin
         job              = '0;
         job.header       = header_ff;
         job.cmd          = RESP_REPORT;
         job.len          = REPORT_LEN;
         job.data[0]      = vin_centivolts[15:8];
         job.data[1]      = vin_centivolts[7:0];
         job.data[2]      = current_one_ma[15:8];
         job.data[3]      = current_one_ma[7:0];
         job.data[4]      = current_two_ma[15:8];
         job.data[5]      = current_two_ma[7:0];
         job.data[6]      = current_three_ma[15:8];
         job.data[7]      = current_three_ma[7:0];
         job.data[8]      = current_four_ma[15:8];
         job.data[9]      = current_four_ma[7:0];
         job.data[10]     = {3'b000, switch_status};
      end
      job.drive_bits = switch_in;
      push = accept && (opcode || finish);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         header_ff <= HEADER_RESET;
         cmd_ff    <= 8'd0;
         len_ff    <= 8'd0;
         count_ff  <= 8'd0;
         limits_ff <= '0;
         switch_ff <= 5'd0;
      end else begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         limits_ff <= limits_in;
         switch_ff <= switch_in;
         if (csr_we) header_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

/* rtl/cfr_queue.sv */
// Small job queue in flip-flops between the parser and the byte sender.
// Depends on cfr_pkg.
module cfr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cfr_pkg::job_type     push_job,
   input  logic                 pop,
   output cfr_pkg::job_type     head_job,
   output cfr_pkg::qstat_type   stat
);
   import cfr_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (do_push && !do_pop)      count_ff <= count_ff + QCNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

/* rtl/cfr_back.sv */
// Back end: walks the head job byte by byte into the output register.
// Depends on cfr_pkg.
module cfr_back (
   input  logic               clock,
   input  logic               reset,
   input  cfr_pkg::job_type   head_job,
   input  cfr_pkg::qstat_type stat,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,
   output logic               rsp_tlast
);
   import cfr_pkg::*;

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff;
   logic [15:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic        load;
   logic [7:0]  tx;
   logic [3:0]  data_idx;
   logic        first;

   assign load     = !stat.empty && (!valid_ff || rsp_tready);
   assign data_idx = idx_ff - 4'd3;
   assign first    = (idx_ff == 4'd0);

   always_comb begin
      case (idx_ff)
         4'd0:    tx = head_job.header;
         4'd1:    tx = head_job.cmd;
         4'd2:    tx = head_job.len;
         default: tx = (data_idx < 4'(CFG_PAYLOAD_BYTES)) ? head_job.data[data_idx] : 8'd0;
      endcase
      // The frame ends on byte index len + 2.
      last_in = ({4'd0, idx_ff} == head_job.len + 8'd2);
      data_in = {1'b0, head_job.save_pulse & first, head_job.drive_bits,
                 head_job.drive_update & first, tx};
      idx_in  = last_in ? 4'd0 : idx_ff + 4'd1;
      pop     = load && last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/command_frame_responder.sv */
// Command frame responder top level: parser, job queue and byte sender.
// Depends on cfr_pkg, cfr_front, cfr_queue and cfr_back.
//
// The req channel carries one received byte per item (tuser = 0) or a
// request for a state report (tuser = 1) together with the measurements.
// The front parses header, command, length and payload one item per cycle
// while the queue is not full, and turns every completed frame or report
// request into a response job. Jobs wait in a four-entry queue; the back
// sends one response byte per cycle on the rsp channel while the receiver
// is ready, with tlast on the final byte of each frame. A frame's job is
// written into the queue when the item that completes it is accepted; with
// an idle sender its first byte is then loaded into the output register.
// Response frames are 4 to 15 bytes long. The front keeps accepting items
// while the sender is busy with earlier frames; req_tready drops only while
// the queue is full. When the receiver stalls, the output register holds
// its byte and the parser keeps accepting items until the queue fills.
// Reset clears the parser, the limits and the switch drive, empties the
// queue and sets the header byte to 0xAA. csr_we writes a new header byte.
module command_frame_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: rx_byte[7:0], vin_centivolts[23:8], current_one_ma[39:24],
   // current_two_ma[55:40], current_three_ma[71:56], current_four_ma[87:72],
   // switch_status[92:88], zero fill[95:93]
   input  logic [95:0] req_tdata,
   // tuser: opcode[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: tx_byte[7:0], drive_update[8], drive_bits[13:9], save_pulse[14],
   // zero fill[15]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);
   import cfr_pkg::*;

   job_type   push_job, head_job;
   qstat_type stat;
   logic      push, pop, accept;

   assign req_tready = !stat.full;
   assign accept     = req_tvalid && req_tready;

   cfr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .accept           (accept),
      .opcode           (req_tuser),
      .rx_byte          (req_tdata[7:0]),
      .vin_centivolts   (req_tdata[23:8]),
      .current_one_ma   (req_tdata[39:24]),
      .current_two_ma   (req_tdata[55:40]),
      .current_three_ma (req_tdata[71:56]),
      .current_four_ma  (req_tdata[87:72]),
      .switch_status    (req_tdata[92:88]),
      .push             (push),
      .job              (push_job)
   );

   cfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (stat)
   );

   cfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .stat       (stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* verif/command_frame_responder_test.sv */
// Self-checking testbench for the command frame responder.
// Needs cfr_pkg and the command_frame_responder RTL; reads no files.
`timescale 1ns / 1ps

module command_frame_responder_test;
   import cfr_pkg::*;

   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_REPORT = 1'b1;
   localparam int   NO_CHECK  = -1;
   localparam int   DIR_ROWS  = 26;
   localparam int   HOLD_CYCLES = 300;
   // Longest legal quiet stretch is the long receiver hold plus a burst or two.
   localparam int   IDLE_LIMIT  = 2000;
   localparam logic [7:0] HDR_LOW  = 8'h00;
   localparam logic [7:0] HDR_HIGH = 8'hFF;

   typedef enum logic [1:0] {SEEK_HEADER, TAKE_CMD, TAKE_LEN, TAKE_DATA} parse_state_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  rx;
      logic [15:0] vin;
      logic [15:0] i1;
      logic [15:0] i2;
      logic [15:0] i3;
      logic [15:0] i4;
      logic [4:0]  sw;
   } link_item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       drive_update;
      logic [4:0] drive_bits;
      logic       save_pulse;
   } resp_byte_type;

   typedef struct {
      logic        op;
      logic [7:0]  rx;
      logic [15:0] meas;
      logic [4:0]  sw;
      int          exp_n;
      logic [7:0]  exp_last;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   command_frame_responder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Predicted block state.
   logic [7:0]      hdr;
   parse_state_type phase;
   logic [7:0]      cmd_l;
   logic [7:0]      len_l;
   logic [7:0]      data_cnt;
   logic [7:0]      stash [CFG_PAYLOAD_BYTES];
   logic [15:0]     limits [LIMIT_COUNT];
   logic [4:0]      drive;

   resp_byte_type bytes_due [$];
   int  faults = 0;
   int  items_sent = 0;
   int  produced_now;
   bit  calm = 1'b0;
   bit  gaps_on = 1'b1;
   bit  hold_rsp = 1'b0;
   int  idle_cycles = 0;
   dir_row_type plan [DIR_ROWS];

   function automatic void put_out(input logic [7:0] b);
      resp_byte_type r;
      r.tx_byte      = b;
      r.last_byte    = 1'b0;
      r.drive_update = 1'b0;
      r.drive_bits   = drive;
      r.save_pulse   = 1'b0;
      bytes_due.push_back(r);
   endfunction

   function automatic void put_word(input logic [15:0] w);
      put_out(w[15:8]);
      put_out(w[7:0]);
   endfunction

   function automatic void put_status(input logic [7:0] resp, input logic [7:0] status);
      put_out(hdr);
      put_out(resp);
      put_out(STATUS_LEN);
      put_out(status);
   endfunction

   // Answer the frame held in cmd_l / len_l / stash.
   function automatic void close_frame();
      int base;
      base = bytes_due.size();
      case (cmd_l)
         CMD_GET_CFG: begin
            if (len_l != 8'd0) begin
               put_status(CMD_GET_CFG | RESP_BIT, STATUS_BAD_LEN);
            end else begin
               put_out(hdr);
               put_out(CMD_GET_CFG | RESP_BIT);
               put_out(8'(2 * LIMIT_COUNT));
               for (int i = 0; i < LIMIT_COUNT; i++) put_word(limits[i]);
            end
         end
         CMD_SET_CFG: begin
            if (len_l != 8'(CFG_PAYLOAD_BYTES)) begin
               put_status(CMD_SET_CFG | RESP_BIT, STATUS_BAD_LEN);
            end else begin
               for (int i = 0; i < LIMIT_COUNT; i++) limits[i] = {stash[2*i], stash[2*i+1]};
               put_status(CMD_SET_CFG | RESP_BIT, STATUS_OK);
            end
         end
         CMD_SAVE: begin
            if (len_l != 8'd0) begin
               put_status(CMD_SAVE | RESP_BIT, STATUS_BAD_LEN);
            end else begin
               put_status(CMD_SAVE | RESP_BIT, STATUS_OK);
               bytes_due[base].save_pulse = 1'b1;
            end
         end
         CMD_SET_SWITCH: begin
            if (len_l != 8'd1) begin
               put_status(CMD_SET_SWITCH | RESP_BIT, STATUS_BAD_LEN);
            end else begin
               drive = stash[0][4:0] & SWITCH_MASK;
               put_status(CMD_SET_SWITCH | RESP_BIT, STATUS_OK);
               bytes_due[base].drive_update = 1'b1;
            end
         end
         default: put_status(cmd_l | RESP_BIT, STATUS_UNKNOWN);
      endcase
   endfunction

   // Queue the response bytes caused by one item; returns how many.
   function automatic int predict_item(input link_item_type it);
      int start;
      start = bytes_due.size();
      if (it.op == OP_REPORT) begin
         put_out(hdr);
         put_out(RESP_REPORT);
         put_out(REPORT_LEN);
         put_word(it.vin);
         put_word(it.i1);
         put_word(it.i2);
         put_word(it.i3);
         put_word(it.i4);
         put_out({3'b000, it.sw});
      end else begin
         case (phase)
            SEEK_HEADER: if (it.rx == hdr) phase = TAKE_CMD;
            TAKE_CMD: begin
               cmd_l = it.rx;
               phase = TAKE_LEN;
            end
            TAKE_LEN: begin
               len_l = it.rx;
               data_cnt = 8'd0;
               if (it.rx == 8'd0) begin
                  close_frame();
                  phase = SEEK_HEADER;
               end else begin
                  phase = TAKE_DATA;
               end
            end
            default: begin
               if (data_cnt < 8'(CFG_PAYLOAD_BYTES)) stash[data_cnt[3:0]] = it.rx;
               data_cnt = data_cnt + 8'd1;
               if (data_cnt == len_l) begin
                  close_frame();
                  phase = SEEK_HEADER;
               end
            end
         endcase
      end
      if (bytes_due.size() > start) bytes_due[bytes_due.size()-1].last_byte = 1'b1;
      return bytes_due.size() - start;
   endfunction

   function automatic link_item_type make_item(input logic op, input logic [7:0] rx);
      link_item_type it;
      it.op  = op;
      it.rx  = rx;
      it.vin = 16'($urandom);
      it.i1  = 16'($urandom);
      it.i2  = 16'($urandom);
      it.i3  = 16'($urandom);
      it.i4  = 16'($urandom);
      it.sw  = 5'($urandom);
      return it;
   endfunction

   task automatic send(input link_item_type it, output int produced);
      @(negedge clock);
      if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {3'b000, it.sw, it.i4, it.i3, it.i2, it.i1, it.vin, it.rx};
      do @(posedge clock); while (!req_tready);
      produced = predict_item(it);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send(make_item(OP_BYTE, b), produced_now);
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
   endtask

   // Only written while idle: the expected responses are drained first, then a pause follows.
   task automatic write_header(input logic [7:0] value);
      drain_all();
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      hdr = value;
   endtask

   task automatic send_random_frame();
      int pick;
      int want;
      logic [7:0] cmd;
      logic [7:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send(make_item(OP_REPORT, 8'($urandom)), produced_now);
      end else if (pick < 22) begin
         send_byte(8'($urandom));
      end else if (pick < 30) begin
         // A header followed by a fragment that runs into whatever comes next.
         send_byte(hdr);
         repeat ($urandom_range(1, 2)) send_byte(8'($urandom));
      end else begin
         case ($urandom_range(0, 5))
            0: begin cmd = CMD_GET_CFG;    want = 0; end
            1: begin cmd = CMD_SET_CFG;    want = CFG_PAYLOAD_BYTES; end
            2: begin cmd = CMD_SAVE;       want = 0; end
            3: begin cmd = CMD_SET_SWITCH; want = 1; end
            4: begin cmd = 8'($urandom);   want = $urandom_range(0, 3); end
            default: begin cmd = 8'($urandom) | RESP_BIT; want = $urandom_range(0, 3); end
         endcase
         len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 20)) : 8'(want);
         send_byte(hdr);
         send_byte(cmd);
         send_byte(len);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
               0: send_byte(8'h00);
               1: send_byte(8'hFF);
               default: send_byte(8'($urandom));
            endcase
         end
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) send_random_frame();
   endtask

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      resp_byte_type got;
      resp_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tx_byte      = rsp_tdata[7:0];
         got.drive_update = rsp_tdata[8];
         got.drive_bits   = rsp_tdata[13:9];
         got.save_pulse   = rsp_tdata[14];
         got.last_byte    = rsp_tlast;
         if (bytes_due.size() == 0) begin
            $error("response item %h with nothing expected", got.tx_byte);
            faults++;
         end else begin
            want = bytes_due.pop_front();
            if (got.tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
               faults++;
            end
            if (got.last_byte !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, got.last_byte);
               faults++;
            end
            if (got.drive_update !== want.drive_update) begin
               $error("drive_update: expected %b, got %b", want.drive_update, got.drive_update);
               faults++;
            end
            if (got.drive_bits !== want.drive_bits) begin
               $error("drive_bits: expected %h, got %h", want.drive_bits, got.drive_bits);
               faults++;
            end
            if (got.save_pulse !== want.save_pulse) begin
               $error("save_pulse: expected %b, got %b", want.save_pulse, got.save_pulse);
               faults++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      dir_row_type row;
      link_item_type it;
      int n;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = 8'h00;
      req_tvalid = 1'b0;
      req_tuser  = OP_BYTE;
      req_tdata  = '0;

      hdr      = HEADER_RESET;
      phase    = SEEK_HEADER;
      cmd_l    = 8'd0;
      len_l    = 8'd0;
      data_cnt = 8'd0;
      drive    = 5'd0;
      for (int i = 0; i < LIMIT_COUNT; i++) limits[i] = 16'd0;

      plan = '{
         '{OP_BYTE,   8'h00,          16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   CMD_GET_CFG,    16'h0000, 5'h00, 0,  8'h00},
         // Limits are still cleared from reset.
         '{OP_BYTE,   8'h00,          16'h0000, 5'h00, 15, 8'h00},
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         // A report in the middle of a frame leaves the parser alone.
         '{OP_REPORT, 8'h00,          16'h0000, 5'h00, 14, 8'h00},
         '{OP_BYTE,   CMD_SAVE,       16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'h00,          16'h0000, 5'h00, 4,  STATUS_OK},
         '{OP_REPORT, 8'hFF,          16'hFFFF, 5'h1F, 14, 8'h1F},
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   CMD_SET_SWITCH, 16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'h01,          16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'h1F,          16'h0000, 5'h00, 4,  STATUS_OK},
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   CMD_GET_CFG,    16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'h01,          16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'hFF,          16'h0000, 5'h00, 4,  STATUS_BAD_LEN},
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'hFF,          16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'h00,          16'h0000, 5'h00, 4,  STATUS_UNKNOWN},
         // A command byte equal to the header is just an unknown command.
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'h00,          16'h0000, 5'h00, 4,  STATUS_UNKNOWN},
         '{OP_BYTE,   HEADER_RESET,   16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   CMD_SET_CFG,    16'h0000, 5'h00, 0,  8'h00},
         '{OP_BYTE,   8'h00,          16'h0000, 5'h00, 4,  STATUS_BAD_LEN}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = plan[r];
         it  = make_item(row.op, row.rx);
         if (row.op == OP_REPORT) begin
            it.vin = row.meas;
            it.i1  = row.meas;
            it.i2  = row.meas;
            it.i3  = row.meas;
            it.i4  = row.meas;
            it.sw  = row.sw;
         end
         send(it, n);
         if (row.exp_n != NO_CHECK && (n != row.exp_n ||
             (n > 0 && bytes_due[bytes_due.size()-1].tx_byte !== row.exp_last))) begin
            $error("directed row %0d: expected %0d items ending %h, predicted %0d",
                   r, row.exp_n, row.exp_last, n);
            faults++;
         end
      end

      write_header(HDR_LOW);
      // Hold the receiver for a long stretch while reports keep coming.
      gaps_on  = 1'b0;
      hold_rsp = 1'b1;
      repeat (10) send(make_item(OP_REPORT, 8'($urandom)), produced_now);
      gaps_on = 1'b1;
      run_random(20);
      drain_all();
      run_random(20);

      write_header(HDR_HIGH);
      run_random(20);
      // A long payload: the bytes beyond the store are counted and dropped.
      send_byte(hdr);
      send_byte(CMD_SET_CFG);
      send_byte(8'd40);
      repeat (40) send_byte(8'($urandom));
      run_random(20);

      write_header(8'($urandom_range(1, 254)));
      run_random(25);

      write_header(HEADER_RESET);
      calm = 1'b1;
      run_random(25);

      drain_all();
      repeat (20) @(posedge clock);
      if (faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
